// ===== rtl/sgnq_pkg.sv =====
// ----------------------------------------------------------------------------
// sgnq_pkg
// Shared types and constants for the sector grid neighbor query unit.
// ----------------------------------------------------------------------------
package sgnq_pkg;

    localparam int COORD_W = 11;
    localparam int ID_W    = 6;

    typedef enum logic {
        OP_MOVE  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ID_W-1:0]     mover_id;
        logic [COORD_W-1:0]  prev_x;
        logic [COORD_W-1:0]  prev_y;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0] neighbor_id;
        logic            found;
        logic            last;
    } t_out_word;

    // which coordinate a sector-map request carries
    typedef enum logic [1:0] {
        TAG_NX = 2'd0,
        TAG_NY = 2'd1,
        TAG_OX = 2'd2,
        TAG_OY = 2'd3
    } t_map_tag;

    typedef struct packed {
        logic               go;
        t_map_tag           tag;
        logic [COORD_W-1:0] coord;
    } t_map_req;

    typedef struct packed {
        logic     done;
        t_map_tag tag;
    } t_map_rsp;

endpackage

// ===== rtl/sgnq_secmap.sv =====
// ----------------------------------------------------------------------------
// sgnq_secmap
// Shared coordinate-to-sector unit: one coordinate per cycle, divided by the
// sector size through a reciprocal multiply, result registered.
// ----------------------------------------------------------------------------
module sgnq_secmap #(
    parameter int SECTOR_SIZE = 128,
    parameter int SECT_W      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sgnq_pkg::t_map_req   i_req,
    output sgnq_pkg::t_map_rsp   o_rsp,
    output logic [SECT_W-1:0]    o_sect
);
    import sgnq_pkg::*;

    // floor(x / d) == (x * ceil(2^(N+l) / d)) >> (N+l) for every N-bit x
    localparam int LOG_D = $clog2(SECTOR_SIZE);
    localparam int SHIFT = COORD_W + LOG_D;
    localparam int MULT  = ((1 << SHIFT) + SECTOR_SIZE - 1) / SECTOR_SIZE;
    localparam int MW    = COORD_W + 2;
    localparam int PW    = COORD_W + MW;
    localparam logic [MW-1:0] MULT_V = MW'(MULT);

    logic [PW-1:0]     w_prod;
    logic              r_done;
    t_map_tag          r_tag;
    logic [SECT_W-1:0] r_sect;

    assign w_prod = PW'(i_req.coord) * PW'(MULT_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_req.tag;
        r_sect <= SECT_W'(w_prod >> SHIFT);
    end

    assign o_rsp.done = r_done;
    assign o_rsp.tag  = r_tag;
    assign o_sect     = r_sect;

endmodule

// ===== rtl/sgnq_mem.sv =====
// ----------------------------------------------------------------------------
// sgnq_mem
// Sector membership bitmap store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgnq_mem #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sgnq_ffs.sv =====
// ----------------------------------------------------------------------------
// sgnq_ffs
// Find the lowest set bit of a membership word: first the lowest nonzero
// byte, then the lowest bit inside it.
// ----------------------------------------------------------------------------
module sgnq_ffs #(
    parameter int DATA_W = 64
) (
    input  logic [DATA_W-1:0]          i_word,
    output logic                       o_any,
    output logic [sgnq_pkg::ID_W-1:0]  o_idx
);
    import sgnq_pkg::*;

    localparam int NGRP = (DATA_W + 7) / 8;
    localparam int PADW = NGRP * 8;

    logic [PADW-1:0] w_pad;
    logic [NGRP-1:0] w_grp_any;
    logic [2:0]      w_grp;
    logic [7:0]      w_byte;
    logic [2:0]      w_bit;

    assign w_pad = PADW'(i_word);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_any[g] = |w_pad[g*8 +: 8];
        end
    end

    always_comb begin
        w_grp = 3'd0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_grp_any[g]) begin
                w_grp = 3'(g);
            end
        end
    end

    assign w_byte = w_pad[w_grp*8 +: 8];

    always_comb begin
        w_bit = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (w_byte[b]) begin
                w_bit = 3'(b);
            end
        end
    end

    assign o_any = |w_grp_any;
    assign o_idx = {w_grp, w_bit};

endmodule

// ===== rtl/sector_grid_neighbor_query_unit.sv =====
// ----------------------------------------------------------------------------
// sector_grid_neighbor_query_unit
// Uniform sector grid with per-sector player bitmaps: moves update the
// bitmaps, queries list the players of the 3x3 sectors around a position.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//
//  One word is worked at a time; the sequencer runs one shared sector-map
//  multiplier and the single read port of the bitmap store.
//  Move: 4 coordinate mappings, then up to two read-modify-writes.
//  Query: 2 coordinate mappings, then the 3x3 sectors in turn: a sector off
//  the grid is skipped, one on it is read and its new ids emitted one by one.
//  After reset the store is cleared, one entry a cycle, all 2**(row bits + col
//  bits) entries (256 at default size); o_in_stall stays high meanwhile.
//  A stalled output word holds until taken; the scan halts once a further id waits.
// ----------------------------------------------------------------------------
module sector_grid_neighbor_query_unit #(
    parameter int WORLD_WIDTH  = 2048,
    parameter int WORLD_HEIGHT = 2048,
    parameter int SECTOR_SIZE  = 128,
    parameter int MAX_PLAYERS  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sgnq_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sgnq_pkg::t_out_word   o_out_word
);
    import sgnq_pkg::*;

    localparam int MAX_COORD = (1 << COORD_W) - 1;
    localparam int REACH     = MAX_COORD / SECTOR_SIZE + 1;
    localparam int SECT_W    = (REACH > 1) ? $clog2(REACH) : 1;
    localparam int COLS_W    = WORLD_WIDTH / SECTOR_SIZE;
    localparam int ROWS_W    = WORLD_HEIGHT / SECTOR_SIZE;
    localparam int NCOLS     = (COLS_W < REACH) ? COLS_W : REACH;
    localparam int NROWS     = (ROWS_W < REACH) ? ROWS_W : REACH;
    localparam int COL_W     = (NCOLS > 1) ? $clog2(NCOLS) : 1;
    localparam int ROW_W     = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int IDX_W     = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
    localparam int NB_W      = SECT_W + 1;

    localparam logic [NB_W-1:0] GRID_COLS  = NB_W'(NCOLS);
    localparam logic [NB_W-1:0] GRID_ROWS  = NB_W'(NROWS);
    localparam logic [ID_W:0]   PLAYERS_V  = (ID_W + 1)'(MAX_PLAYERS);
    localparam logic [2:0]      MAP_LAST_Q = 3'd1;
    localparam logic [2:0]      MAP_LAST_M = 3'd3;
    localparam logic [1:0]      NB_LAST    = 2'd2;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_MAP    = 11'b000_0000_0100,
        S_MV_ORD = 11'b000_0000_1000,
        S_MV_OWR = 11'b000_0001_0000,
        S_MV_NRD = 11'b000_0010_0000,
        S_MV_NWR = 11'b000_0100_0000,
        S_Q_RD   = 11'b000_1000_0000,
        S_Q_LOAD = 11'b001_0000_0000,
        S_Q_EMIT = 11'b010_0000_0000,
        S_Q_END  = 11'b100_0000_0000
    } t_state;

    t_state                 r_state, n_state;
    t_in_word               r_item, n_item;
    logic [2:0]             r_cnt, n_cnt;
    logic [SECT_W-1:0]      r_nx, r_ny, r_ox, r_oy;
    logic [1:0]             r_dx, n_dx, r_dy, n_dy;
    logic [MAX_PLAYERS-1:0] r_word, n_word;
    logic [MAX_PLAYERS-1:0] r_seen, n_seen;
    logic                   r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]        r_pend_id, n_pend_id;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;

    t_map_req               w_map_req;
    t_map_rsp               w_map_rsp;
    logic [SECT_W-1:0]      w_map_sect;

    logic                   w_mem_we, w_mem_re;
    logic [ADDR_W-1:0]      w_mem_waddr, w_mem_raddr;
    logic [MAX_PLAYERS-1:0] w_mem_wdata, w_mem_rdata;

    logic                   w_ffs_any;
    logic [ID_W-1:0]        w_ffs_idx;

    logic [2:0]             w_map_last;
    logic                   w_pid_ok, w_moved, w_old_in, w_new_in;
    logic [ADDR_W-1:0]      w_old_addr, w_new_addr, w_nb_addr;
    logic [NB_W-1:0]        w_cand_c, w_cand_r, w_nb_c, w_nb_r;
    logic                   w_nb_in, w_nb_last;
    logic [MAX_PLAYERS-1:0] w_pbit;
    logic                   w_out_free, w_emit;
    t_out_word              w_emit_word;

    sgnq_secmap #(
        .SECTOR_SIZE (SECTOR_SIZE),
        .SECT_W      (SECT_W)
    ) u_secmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_map_req),
        .o_rsp   (w_map_rsp),
        .o_sect  (w_map_sect)
    );

    sgnq_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (MAX_PLAYERS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    sgnq_ffs #(
        .DATA_W (MAX_PLAYERS)
    ) u_ffs (
        .i_word (r_word),
        .o_any  (w_ffs_any),
        .o_idx  (w_ffs_idx)
    );

    // sector-map requests: one coordinate per cycle while mapping
    assign w_map_last = (r_item.opcode == OP_QUERY) ? MAP_LAST_Q : MAP_LAST_M;

    always_comb begin
        w_map_req.go  = (r_state == S_MAP) && (r_cnt <= w_map_last);
        w_map_req.tag = t_map_tag'(r_cnt[1:0]);
        unique case (t_map_tag'(r_cnt[1:0]))
            TAG_NX:  w_map_req.coord = r_item.pos_x;
            TAG_NY:  w_map_req.coord = r_item.pos_y;
            TAG_OX:  w_map_req.coord = r_item.prev_x;
            TAG_OY:  w_map_req.coord = r_item.prev_y;
            default: w_map_req.coord = r_item.pos_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_map_rsp.done) begin
            unique case (w_map_rsp.tag)
                TAG_NX:  r_nx <= w_map_sect;
                TAG_NY:  r_ny <= w_map_sect;
                TAG_OX:  r_ox <= w_map_sect;
                TAG_OY:  r_oy <= w_map_sect;
                default: r_nx <= w_map_sect;
            endcase
        end
    end

    // move decode
    assign w_pid_ok   = {1'b0, r_item.mover_id} < PLAYERS_V;
    assign w_moved    = (r_ox != r_nx) || (r_oy != r_ny);
    assign w_old_in   = (NB_W'(r_ox) < GRID_COLS) && (NB_W'(r_oy) < GRID_ROWS);
    assign w_new_in   = (NB_W'(r_nx) < GRID_COLS) && (NB_W'(r_ny) < GRID_ROWS);
    assign w_old_addr = {r_oy[ROW_W-1:0], r_ox[COL_W-1:0]};
    assign w_new_addr = {r_ny[ROW_W-1:0], r_nx[COL_W-1:0]};
    assign w_pbit     = MAX_PLAYERS'(1) << r_item.mover_id[IDX_W-1:0];

    // neighbor sector at offset (dx-1, dy-1)
    assign w_cand_c  = NB_W'(r_nx) + NB_W'(r_dx);
    assign w_cand_r  = NB_W'(r_ny) + NB_W'(r_dy);
    assign w_nb_c    = w_cand_c - NB_W'(1);
    assign w_nb_r    = w_cand_r - NB_W'(1);
    assign w_nb_in   = (w_cand_c != '0) && (w_cand_r != '0)
                       && (w_nb_c < GRID_COLS) && (w_nb_r < GRID_ROWS);
    assign w_nb_addr = {w_nb_r[ROW_W-1:0], w_nb_c[COL_W-1:0]};
    assign w_nb_last = (r_dx == NB_LAST) && (r_dy == NB_LAST);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_cnt        = r_cnt;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_word       = r_word;
        n_seen       = r_seen;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_clr_addr   = r_clr_addr;
        w_mem_we     = 1'b0;
        w_mem_waddr  = w_old_addr;
        w_mem_wdata  = '0;
        w_mem_re     = 1'b0;
        w_mem_raddr  = w_nb_addr;
        w_emit       = 1'b0;
        w_emit_word  = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_word;
                    n_cnt        = '0;
                    n_dx         = '0;
                    n_dy         = '0;
                    n_seen       = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_MAP;
                end
            end
            S_MAP: begin
                n_cnt = r_cnt + 3'd1;
                // last mapping lands in its register on this edge
                if (r_cnt == w_map_last + 3'd1) begin
                    n_state = (r_item.opcode == OP_QUERY) ? S_Q_RD : S_MV_ORD;
                end
            end
            S_MV_ORD: begin
                priority if (!w_pid_ok || !w_moved) begin
                    n_state = S_IDLE;
                end else if (w_old_in) begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = w_old_addr;
                    n_state     = S_MV_OWR;
                end else if (w_new_in) begin
                    n_state = S_MV_NRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MV_OWR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_old_addr;
                w_mem_wdata = w_mem_rdata & ~w_pbit;
                n_state     = w_new_in ? S_MV_NRD : S_IDLE;
            end
            S_MV_NRD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = w_new_addr;
                n_state     = S_MV_NWR;
            end
            S_MV_NWR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_new_addr;
                w_mem_wdata = w_mem_rdata | w_pbit;
                n_state     = S_IDLE;
            end
            S_Q_RD: begin
                if (w_nb_in) begin
                    w_mem_re = 1'b1;
                    n_state  = S_Q_LOAD;
                end else if (w_nb_last) begin
                    n_state = S_Q_END;
                end else if (r_dx == NB_LAST) begin
                    n_dx = '0;
                    n_dy = r_dy + 2'd1;
                end else begin
                    n_dx = r_dx + 2'd1;
                end
            end
            S_Q_LOAD: begin
                // drop ids already listed from an earlier sector
                n_word  = w_mem_rdata & ~r_seen;
                n_seen  = r_seen | w_mem_rdata;
                n_state = S_Q_EMIT;
            end
            S_Q_EMIT: begin
                priority if (!w_ffs_any) begin
                    if (w_nb_last) begin
                        n_state = S_Q_END;
                    end else begin
                        n_state = S_Q_RD;
                        if (r_dx == NB_LAST) begin
                            n_dx = '0;
                            n_dy = r_dy + 2'd1;
                        end else begin
                            n_dx = r_dx + 2'd1;
                        end
                    end
                end else if (!r_pend_valid) begin
                    n_pend_valid                  = 1'b1;
                    n_pend_id                     = w_ffs_idx;
                    n_word[w_ffs_idx[IDX_W-1:0]]  = 1'b0;
                end else if (w_out_free) begin
                    // a later id exists, so the held one is not the last
                    w_emit                        = 1'b1;
                    w_emit_word.neighbor_id       = r_pend_id;
                    w_emit_word.found             = 1'b1;
                    w_emit_word.last              = 1'b0;
                    n_pend_id                     = w_ffs_idx;
                    n_word[w_ffs_idx[IDX_W-1:0]]  = 1'b0;
                end else begin
                    n_state = S_Q_EMIT;
                end
            end
            S_Q_END: begin
                if (w_out_free) begin
                    w_emit                  = 1'b1;
                    w_emit_word.neighbor_id = r_pend_valid ? r_pend_id : '0;
                    w_emit_word.found       = r_pend_valid;
                    w_emit_word.last        = 1'b1;
                    n_pend_valid            = 1'b0;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_out_valid = w_out_free ? w_emit : r_out_valid;
    assign n_out_word  = w_emit ? w_emit_word : r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_cnt        <= '0;
            r_dx         <= '0;
            r_dy         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cnt        <= n_cnt;
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_word     <= n_word;
        r_seen     <= n_seen;
        r_pend_id  <= n_pend_id;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/sgnq_chk.sv =====
// ----------------------------------------------------------------------------
// sgnq_chk
// Port-level checks for the sector grid neighbor query unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module sgnq_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_stall,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input sgnq_pkg::t_out_word  i_out_word
);
    import sgnq_pkg::*;

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("stalled output word changed");

    // an accepted word keeps the unit busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input accepted twice in a row");

    // the empty-query word is the final one and carries id zero
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_word.found
            |-> i_out_word.last && (i_out_word.neighbor_id == '0))
        else $error("malformed empty-query word");

endmodule

bind sector_grid_neighbor_query_unit sgnq_chk u_sgnq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);
